// ===== rtl/rrsr_pkg.sv =====
// Shared types, constants and the corner inset table for the rounded
// rectangle span rasterizer. No dependencies.
package rrsr_pkg;

  localparam int unsigned CoordW = 15;
  localparam int unsigned SpanXyW = 16;
  localparam int unsigned SpanWhW = 14;
  localparam int unsigned RadW = 4;
  localparam int unsigned MathW = 18;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWS,
    ST_TAIL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic            load;
    logic            step;
    logic            tail;
    logic            flush;
    logic [RadW-1:0] row;
    logic [1:0]      sub;
  } cmd_t;

  typedef struct packed {
    logic rows_done;
    logic stall;
    logic out_free;
  } sts_t;

  typedef logic [255:0][RadW-1:0] inset_tab_t;

  // inset(r,i) = (2r+1-c)/2, c the ceiling integer square root of 4r^2-(2r-2i-1)^2
  function automatic inset_tab_t build_inset_tab();
    inset_tab_t tab;
    int d;
    int q;
    int c;
    tab = '0;
    for (int r = 0; r < 16; r++) begin
      for (int i = 0; i < 16; i++) begin
        d = 2 * r - 2 * i - 1;
        q = 4 * r * r - d * d;
        if (q <= 0) begin
          tab[r * 16 + i] = RadW'(r);
        end else begin
          c = 64;
          for (int s = 63; s >= 0; s--) begin
            if (s * s >= q) c = s;
          end
          tab[r * 16 + i] = RadW'((2 * r + 1 - c) / 2);
        end
      end
    end
    return tab;
  endfunction

  localparam inset_tab_t InsetTab = build_inset_tab();

endpackage

// ===== rtl/rounded_rect_span_raster.sv =====
// Rounded rectangle span rasterizer: one rectangle in, up to 60 spans out.
// The sequencer takes one slot per cycle unless the output stalls: four slots per
// corner row plus one row check, four tail slots, one flush and one idle state.
// A rounded rectangle has one corner row per unit of its clamped radius, which is
// at most MAX_RADIUS. One rectangle at a time; each span is held until a later
// span or the flush shows whether it is the last; no span gives an empty marker.
// Reset (rst_ni low, asynchronous) clears the sequencer and all valid flags.
module rounded_rect_span_raster #(
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rect_x[14:0], rect_y[29:15], rect_w[44:30], rect_h[59:45], radius[74:60],
  // corner_mask[78:75], zero[79]
  input  logic [79:0] s_axis_tdata,
  // kind[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // span_x[15:0], span_y[31:16], span_w[45:32], span_h[59:46], zero[63:60]
  output logic [63:0] m_axis_tdata,
  // empty_res[0]
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  rrsr_pkg::cmd_t cmd;
  rrsr_pkg::sts_t sts;
  logic [15:0] sx, sy;
  logic [13:0] sw, sh;

  rrsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrsr_dp #(.MAX_RADIUS(MAX_RADIUS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (s_axis_tuser),
    .rect_x_i      (s_axis_tdata[14:0]),
    .rect_y_i      (s_axis_tdata[29:15]),
    .rect_w_i      (s_axis_tdata[44:30]),
    .rect_h_i      (s_axis_tdata[59:45]),
    .radius_i      (s_axis_tdata[74:60]),
    .corner_mask_i (s_axis_tdata[78:75]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .span_x_o      (sx),
    .span_y_o      (sy),
    .span_w_o      (sw),
    .span_h_o      (sh),
    .last_o        (m_axis_tlast),
    .empty_res_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, sh, sw, sy, sx};

endmodule

// ===== rtl/rrsr_ctrl.sv =====
// Sequencer for the span rasterizer: walks corner rows and four slots per
// row, then the tail spans, then flushes the held span. Uses rrsr_pkg.
module rrsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rrsr_pkg::sts_t sts_i,
  output rrsr_pkg::cmd_t cmd_o
);

  rrsr_pkg::state_e state_q, state_d;
  logic [rrsr_pkg::RadW-1:0] row_q, row_d;
  logic [1:0] sub_q, sub_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrsr_pkg::ST_IDLE;
      row_q   <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      sub_q   <= sub_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    sub_d      = sub_q;
    cmd_o      = '0;
    cmd_o.row  = row_q;
    cmd_o.sub  = sub_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      rrsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rrsr_pkg::ST_ROWS;
          row_d      = '0;
          sub_d      = '0;
        end
      end
      rrsr_pkg::ST_ROWS: begin
        if (sts_i.rows_done) begin
          state_d = rrsr_pkg::ST_TAIL;
          sub_d   = '0;
        end else begin
          cmd_o.step = 1'b1;
          if (!sts_i.stall) begin
            sub_d = sub_q + 2'd1;
            if (sub_q == 2'd3) row_d = row_q + 1'b1;
          end
        end
      end
      rrsr_pkg::ST_TAIL: begin
        cmd_o.step = 1'b1;
        cmd_o.tail = 1'b1;
        if (!sts_i.stall) begin
          sub_d = sub_q + 2'd1;
          if (sub_q == 2'd3) state_d = rrsr_pkg::ST_FLUSH;
        end
      end
      rrsr_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.out_free) state_d = rrsr_pkg::ST_IDLE;
      end
      default: state_d = rrsr_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/rrsr_dp.sv =====
// Datapath for the span rasterizer: input registers, radius clamp, inset
// lookup, span arithmetic, one held span and the output register. Uses rrsr_pkg.
module rrsr_dp #(
  parameter int unsigned MAX_RADIUS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rrsr_pkg::cmd_t                      cmd_i,
  output rrsr_pkg::sts_t                      sts_o,
  input  logic                                kind_i,
  input  logic signed [rrsr_pkg::CoordW-1:0]  rect_x_i,
  input  logic signed [rrsr_pkg::CoordW-1:0]  rect_y_i,
  input  logic signed [rrsr_pkg::CoordW-1:0]  rect_w_i,
  input  logic signed [rrsr_pkg::CoordW-1:0]  rect_h_i,
  input  logic signed [rrsr_pkg::CoordW-1:0]  radius_i,
  input  logic [3:0]                          corner_mask_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rrsr_pkg::SpanXyW-1:0] span_x_o,
  output logic signed [rrsr_pkg::SpanXyW-1:0] span_y_o,
  output logic [rrsr_pkg::SpanWhW-1:0]        span_w_o,
  output logic [rrsr_pkg::SpanWhW-1:0]        span_h_o,
  output logic                                last_o,
  output logic                                empty_res_o
);

  localparam int unsigned MW = rrsr_pkg::MathW;
  localparam int unsigned CW = rrsr_pkg::CoordW;
  localparam int unsigned RW = rrsr_pkg::RadW;

  logic kind_q;
  logic signed [CW-1:0] x_q, y_q, w_q, h_q;
  logic [RW-1:0] rad_q;
  logic [3:0] mask_q;
  logic rnd_q;

  logic [CW-1:0] rad_c;
  always_comb begin
    rad_c = '0;
    if (radius_i > 0 && rect_w_i > 0 && rect_h_i > 0) begin
      rad_c = CW'(radius_i);
      if (rad_c > CW'(rect_w_i >>> 1)) rad_c = CW'(rect_w_i >>> 1);
      if (rad_c > CW'(rect_h_i >>> 1)) rad_c = CW'(rect_h_i >>> 1);
      if (rad_c > CW'(MAX_RADIUS)) rad_c = CW'(MAX_RADIUS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      x_q    <= rect_x_i;
      y_q    <= rect_y_i;
      w_q    <= rect_w_i;
      h_q    <= rect_h_i;
      rad_q  <= rad_c[RW-1:0];
      mask_q <= corner_mask_i;
      rnd_q  <= (rad_c != '0) && (corner_mask_i != 4'd0);
    end
  end

  // inset of this row and of the row above, per corner where rounded
  logic [RW-1:0] ins_cur, ins_prv;
  logic [RW-1:0] rowm1;
  assign rowm1   = cmd_i.row - 1'b1;
  assign ins_cur = rrsr_pkg::InsetTab[{rad_q, cmd_i.row}];
  assign ins_prv = rrsr_pkg::InsetTab[{rad_q, rowm1}];

  logic signed [MW-1:0] xs, ys, ws, hs, rs, is;
  logic signed [MW-1:0] c0, c1, c2, c3, p0, p1, p2, p3;
  logic signed [MW-1:0] cx, cy, cw, ch;
  logic used, cand_v;

  always_comb begin
    xs = MW'(x_q);
    ys = MW'(y_q);
    ws = MW'(w_q);
    hs = MW'(h_q);
    rs = MW'(signed'({1'b0, rad_q}));
    is = MW'(signed'({1'b0, cmd_i.row}));
    c0 = mask_q[0] ? MW'(signed'({1'b0, ins_cur})) : '0;
    c1 = mask_q[1] ? MW'(signed'({1'b0, ins_cur})) : '0;
    c2 = mask_q[2] ? MW'(signed'({1'b0, ins_cur})) : '0;
    c3 = mask_q[3] ? MW'(signed'({1'b0, ins_cur})) : '0;
    p0 = mask_q[0] ? MW'(signed'({1'b0, ins_prv})) : '0;
    p1 = mask_q[1] ? MW'(signed'({1'b0, ins_prv})) : '0;
    p2 = mask_q[2] ? MW'(signed'({1'b0, ins_prv})) : '0;
    p3 = mask_q[3] ? MW'(signed'({1'b0, ins_prv})) : '0;
    cx = xs;
    cy = ys;
    cw = ws;
    ch = MW'(1);
    used = 1'b0;
    if (!cmd_i.tail) begin
      if (!kind_q || cmd_i.row == '0) begin
        unique case (cmd_i.sub)
          2'd0: begin
            used = 1'b1; cx = xs + c0; cy = ys + is; cw = ws - c0 - c1;
          end
          2'd1: begin
            used = 1'b1; cx = xs + c2; cy = ys + hs - MW'(1) - is; cw = ws - c2 - c3;
          end
          default: used = 1'b0;
        endcase
      end else begin
        used = 1'b1;
        unique case (cmd_i.sub)
          2'd0: begin
            cx = xs + c0; cy = ys + is; cw = (p0 > c0) ? p0 - c0 : MW'(1);
          end
          2'd1: begin
            cx = xs + ws - ((p1 > c1) ? p1 : c1 + MW'(1)); cy = ys + is;
            cw = (p1 > c1) ? p1 - c1 : MW'(1);
          end
          2'd2: begin
            cx = xs + c2; cy = ys + hs - MW'(1) - is;
            cw = (p2 > c2) ? p2 - c2 : MW'(1);
          end
          default: begin
            cx = xs + ws - ((p3 > c3) ? p3 : c3 + MW'(1)); cy = ys + hs - MW'(1) - is;
            cw = (p3 > c3) ? p3 - c3 : MW'(1);
          end
        endcase
      end
    end else if (!kind_q) begin
      used = (cmd_i.sub == 2'd0);
      if (rnd_q) begin
        cy = ys + rs; ch = hs - (rs <<< 1);
      end else begin
        ch = hs;
      end
    end else if (w_q > 0 && h_q > 0) begin
      if (rnd_q) begin
        used = (cmd_i.sub == 2'd0) || (cmd_i.sub == 2'd1);
        cx = (cmd_i.sub == 2'd1) ? xs + ws - MW'(1) : xs;
        cy = ys + rs; cw = MW'(1); ch = hs - (rs <<< 1);
      end else begin
        used = 1'b1;
        unique case (cmd_i.sub)
          2'd0: ch = MW'(1);
          2'd1: begin cx = xs + ws - MW'(1); cw = MW'(1); ch = hs; end
          2'd2: begin cy = ys + hs - MW'(1); ch = MW'(1); end
          default: begin cw = MW'(1); ch = hs; end
        endcase
      end
    end
    cand_v = cmd_i.step && used && (cw > 0) && (ch > 0);
  end

  // held span: sent on once a later span shows it is not the last, or by the flush as the last
  logic pend_v_q, pend_v_d;
  logic signed [rrsr_pkg::SpanXyW-1:0] pend_x_q, pend_y_q;
  logic [rrsr_pkg::SpanWhW-1:0] pend_w_q, pend_h_q;
  logic out_v_q, out_v_d, out_free, out_load;
  logic [rrsr_pkg::SpanXyW-1:0] out_x_q, out_y_q;
  logic [rrsr_pkg::SpanWhW-1:0] out_w_q, out_h_q;
  logic out_last_q, out_empty_q;
  logic stall, commit;

  assign out_free = !out_v_q || out_ready_i;
  assign stall    = cand_v && pend_v_q && !out_free;
  assign commit   = cand_v && !stall;
  assign out_load = (commit && pend_v_q) || (cmd_i.flush && out_free);

  always_comb begin
    pend_v_d = pend_v_q;
    if (commit) pend_v_d = 1'b1;
    else if (cmd_i.flush && out_free) pend_v_d = 1'b0;
    out_v_d = out_v_q && !out_ready_i;
    if (out_load) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      pend_x_q <= cx[rrsr_pkg::SpanXyW-1:0];
      pend_y_q <= cy[rrsr_pkg::SpanXyW-1:0];
      pend_w_q <= cw[rrsr_pkg::SpanWhW-1:0];
      pend_h_q <= ch[rrsr_pkg::SpanWhW-1:0];
    end
    if (out_load) begin
      out_x_q     <= pend_v_q ? pend_x_q : '0;
      out_y_q     <= pend_v_q ? pend_y_q : '0;
      out_w_q     <= pend_v_q ? pend_w_q : '0;
      out_h_q     <= pend_v_q ? pend_h_q : '0;
      out_last_q  <= cmd_i.flush;
      out_empty_q <= cmd_i.flush && !pend_v_q;
    end
  end

  assign sts_o.rows_done = !rnd_q || (cmd_i.row >= rad_q);
  assign sts_o.stall     = stall;
  assign sts_o.out_free  = out_free;

  assign out_valid_o = out_v_q;
  assign span_x_o    = out_x_q;
  assign span_y_o    = out_y_q;
  assign span_w_o    = out_w_q;
  assign span_h_o    = out_h_q;
  assign last_o      = out_last_q;
  assign empty_res_o = out_empty_q;

endmodule

// ===== rtl/rrsr_chk.sv =====
// Port-level checker for the span rasterizer, bound to the top level.
// Depends only on the top-level ports.
module rrsr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 64'd0))
    else $error("empty result not last or not zero");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a rectangle is in work");

endmodule

bind rounded_rect_span_raster rrsr_chk u_rrsr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/tb_rounded_rect_span_raster.sv =====
// Testbench for rounded_rect_span_raster: drives rectangles over the input stream,
// predicts every span in software and checks the output stream in order.
// Depends on rtl/rounded_rect_span_raster.sv, rtl/rrsr_ctrl.sv, rtl/rrsr_dp.sv and rtl/rrsr_pkg.sv.
module tb_rounded_rect_span_raster;

  localparam int MaxRad = 15;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [13:0]        w;
    logic [13:0]        h;
    logic               lst;
    logic               emp;
  } span_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  span_t span_q[$];
  span_t found[$];
  int    mismatches;
  int    burst_left;
  logic  stall_en;

  rounded_rect_span_raster #(.MAX_RADIUS(MaxRad)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("tb_rounded_rect_span_raster: errors");
    $finish;
  end

  function automatic int ceil_root(int n);
    int s;
    s = 0;
    while (s * s < n) s++;
    return s;
  endfunction

  function automatic int row_inset(int rad, int row);
    int d;
    int q;
    d = 2 * rad - 2 * row - 1;
    q = 4 * rad * rad - d * d;
    if (q <= 0) return rad;
    return (2 * rad + 1 - ceil_root(q)) / 2;
  endfunction

  function automatic int cin(logic [3:0] m, int b, int rad, int row);
    return m[b] ? row_inset(rad, row) : 0;
  endfunction

  function automatic void add_span(int x, int y, int w, int h);
    span_t s;
    if (w > 0 && h > 0 && found.size() < 62) begin
      s.x = x[15:0]; s.y = y[15:0]; s.w = w[13:0]; s.h = h[13:0];
      s.lst = 0; s.emp = 0;
      found.push_back(s);
    end
  endfunction

  // Build the expected span list of one rectangle and queue it.
  function automatic void predict_spans(logic kind, int x, int y, int w, int h, int r0,
                                        logic [3:0] m);
    int rad;
    int l, r, lp, rp, bl, br, blp, brp;
    span_t e;
    found.delete();
    rad = r0;
    if (rad > w / 2) rad = w / 2;
    if (rad > h / 2) rad = h / 2;
    if (rad < 0) rad = 0;
    if (rad > MaxRad) rad = MaxRad;
    if (!kind) begin
      if (rad <= 0 || m == 0) add_span(x, y, w, h);
      else begin
        for (int i = 0; i < rad; i++) begin
          l = cin(m, 0, rad, i); r = cin(m, 1, rad, i);
          add_span(x + l, y + i, w - l - r, 1);
          l = cin(m, 2, rad, i); r = cin(m, 3, rad, i);
          add_span(x + l, y + h - 1 - i, w - l - r, 1);
        end
        add_span(x, y + rad, w, h - 2 * rad);
      end
    end else if (w > 0 && h > 0) begin
      if (rad <= 0 || m == 0) begin
        add_span(x, y, w, 1);
        add_span(x + w - 1, y, 1, h);
        add_span(x, y + h - 1, w, 1);
        add_span(x, y, 1, h);
      end else begin
        for (int i = 0; i < rad; i++) begin
          l = cin(m, 0, rad, i); r = cin(m, 1, rad, i);
          bl = cin(m, 2, rad, i); br = cin(m, 3, rad, i);
          if (i == 0) begin
            add_span(x + l, y, w - l - r, 1);
            add_span(x + bl, y + h - 1, w - bl - br, 1);
          end else begin
            lp = cin(m, 0, rad, i - 1); rp = cin(m, 1, rad, i - 1);
            blp = cin(m, 2, rad, i - 1); brp = cin(m, 3, rad, i - 1);
            add_span(x + l, y + i, lp > l ? lp - l : 1, 1);
            add_span(x + w - (rp > r ? rp : r + 1), y + i, rp > r ? rp - r : 1, 1);
            add_span(x + bl, y + h - 1 - i, blp > bl ? blp - bl : 1, 1);
            add_span(x + w - (brp > br ? brp : br + 1), y + h - 1 - i,
                     brp > br ? brp - br : 1, 1);
          end
        end
        add_span(x, y + rad, 1, h - 2 * rad);
        add_span(x + w - 1, y + rad, 1, h - 2 * rad);
      end
    end
    if (found.size() == 0) begin
      e.x = 0; e.y = 0; e.w = 0; e.h = 0; e.lst = 1; e.emp = 1;
      span_q.push_back(e);
    end else begin
      found[found.size() - 1].lst = 1;
      foreach (found[k]) span_q.push_back(found[k]);
    end
  endfunction

  // Send one rectangle, honoring the burst/gap pattern.
  task automatic send_rect(logic kind, logic [14:0] x, logic [14:0] y, logic [14:0] w,
                           logic [14:0] h, logic [14:0] r, logic [3:0] m);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, m, r, h, w, y, x};
    predict_spans(kind, $signed(x), $signed(y), $signed(w), $signed(h), $signed(r), m);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_wait();
    if (burst_left != 0) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (span_q.size() != 0) @(negedge clk_i);
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    span_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (span_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected span %h", m_axis_tdata);
      end else begin
        e = span_q.pop_front();
        if (m_axis_tdata[15:0] !== e.x || m_axis_tdata[31:16] !== e.y ||
            m_axis_tdata[45:32] !== e.w || m_axis_tdata[59:46] !== e.h ||
            m_axis_tlast !== e.lst || m_axis_tuser !== e.emp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("span mismatch: exp x=%0d y=%0d w=%0d h=%0d last=%b empty=%b",
                     e.x, e.y, e.w, e.h, e.lst, e.emp);
            $display("               got x=%0d y=%0d w=%0d h=%0d last=%b empty=%b",
                     $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                     m_axis_tdata[45:32], m_axis_tdata[59:46], m_axis_tlast, m_axis_tuser);
          end
        end
      end
    end
  end

  // Receiver stall pattern: alternating free and stalling phases.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_en <= ~stall_en;
    m_axis_tready <= stall_en ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  task automatic test_extremes();
    send_rect(0, 15'h4000, 15'h4000, 15'h3fff, 15'h3fff, 15'h3fff, 4'hf);
    send_rect(1, 15'h3fff, 15'h3fff, 15'h3fff, 15'h3fff, 15'h4000, 4'hf);
    send_rect(0, 15'h3fff, 15'h3fff, 15'h3fff, 15'h3fff, 15'd0, 4'hf);
    send_rect(0, 15'd5, 15'd5, 15'h4000, 15'd10, 15'd3, 4'hf);
    send_rect(1, 15'd5, 15'd5, 15'd10, 15'd0, 15'd3, 4'hf);
    send_rect(0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 4'h0);
  endtask

  task automatic test_shapes();
    send_rect(1, 15'd1, 15'd2, 15'd8, 15'd6, 15'd0, 4'hf);
    send_rect(1, 15'd1, 15'd2, 15'd8, 15'd6, 15'd3, 4'h0);
    send_rect(1, 15'd1, 15'd1, 15'd1, 15'd1, 15'd0, 4'h0);
    send_rect(0, 15'd0, 15'd0, 15'd40, 15'd40, 15'd15, 4'hf);
    send_rect(1, 15'd0, 15'd0, 15'd40, 15'd40, 15'd15, 4'hf);
    send_rect(1, 15'd3, 15'd3, 15'd31, 15'd31, 15'd15, 4'h5);
    send_rect(0, 15'd3, 15'd3, 15'd30, 15'd30, 15'd20, 4'h9);
    send_rect(0, 15'd2, 15'd2, 15'd2, 15'd2, 15'd1, 4'hf);
    send_rect(1, 15'd2, 15'd2, 15'd2, 15'd2, 15'd1, 4'hf);
    send_rect(0, 15'd2, 15'd2, 15'd4, 15'd40, 15'd9, 4'h6);
    send_rect(1, -15'sd7, 15'd0, 15'd9, 15'd4, 15'd2, 4'ha);
    drain_wait();
  endtask

  task automatic test_random();
    logic [14:0] w, h, r;
    for (int n = 0; n < 280; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        w = 15'($urandom); h = 15'($urandom); r = 15'($urandom);
      end else begin
        w = 15'($urandom_range(0, 40)) - 15'd2;
        h = 15'($urandom_range(0, 40)) - 15'd2;
        r = 15'($urandom_range(0, 22)) - 15'd2;
      end
      send_rect(1'($urandom_range(0, 1)), 15'($urandom), 15'($urandom), w, h, r,
                4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    stall_en = 1'b0;
    mismatches = 0;
    burst_left = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_shapes();
    test_random();
    drain_wait();
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && span_q.size() == 0) begin
      $display("tb_rounded_rect_span_raster: clean");
    end else begin
      $display("tb_rounded_rect_span_raster: errors");
    end
    $finish;
  end

endmodule
